// ===== hw/rtl/gda_pkg.sv =====
`default_nettype none

package gda_pkg;

  // field widths
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned OFF_W   = 20;
  localparam int unsigned COUNT_W = 22;

  // internal widths: day numbers and shift sums span about -525k .. 6.5M
  localparam int unsigned SER_W   = 24;
  localparam int unsigned PC_W    = 5;
  localparam int unsigned Q_W     = 8;
  localparam int unsigned MUL_A_W = 22;
  localparam int unsigned MUL_B_W = 13;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // calendar limits
  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic signed [SER_W-1:0] SERIAL_LAST = 24'sd3652058;
  localparam logic signed [SER_W-1:0] YEAR0_START = -24'sd366;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // reciprocal constants: q100 = (y * 5243) >> 19 exact for y < 16384,
  // year estimate = (s * 2871) >> 20 within about one year
  localparam logic [MUL_B_W-1:0] RECIP_100    = 13'd5243;
  localparam int unsigned        RECIP_100_SH = 19;
  localparam logic [MUL_B_W-1:0] RECIP_YEAR    = 13'd2871;
  localparam int unsigned        RECIP_YEAR_SH = 20;

  // opcodes
  localparam logic OPC_SHIFT = 1'b0;
  localparam logic OPC_DIFF  = 1'b1;

  typedef logic [YEAR_W-1:0]         year_t;
  typedef logic [MONTH_W-1:0]        month_t;
  typedef logic [DAY_W-1:0]          day_t;
  typedef logic [Q_W-1:0]            q_t;
  typedef logic [PC_W-1:0]           pc_t;
  typedef logic signed [SER_W-1:0]   serial_t;

  typedef struct packed {
    logic                    opcode;
    year_t                   a_year;
    month_t                  a_month;
    day_t                    a_day;
    year_t                   b_year;
    month_t                  b_month;
    day_t                    b_day;
    logic signed [OFF_W-1:0] offset_days;
  } gda_req_t;

  typedef struct packed {
    year_t              out_year;
    month_t             out_month;
    day_t               out_day;
    logic [COUNT_W-1:0] day_count;
    logic               a_before_b;
    logic               a_equals_b;
    logic               a_invalid;
    logic               out_of_range;
  } gda_rsp_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    UOP_NOP,
    UOP_LOAD_A,
    UOP_LOAD_B,
    UOP_Q_Y,
    UOP_Q_P,
    UOP_LEAP,
    UOP_YS,
    UOP_YS_NEXT,
    UOP_SER,
    UOP_SAVE_A,
    UOP_SHIFT_ADD,
    UOP_EST,
    UOP_INC,
    UOP_DEC,
    UOP_SUB_YS,
    UOP_MSTEP,
    UOP_FINISH
  } uop_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_OP_SHIFT,
    COND_UP_DONE,
    COND_DOWN_DONE,
    COND_MONTH_DONE
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // program addresses
  localparam pc_t PC_START = 5'd0;
  localparam pc_t PC_SHIFT = 5'd14;
  localparam pc_t PC_UP    = 5'd16;
  localparam pc_t PC_DOWN  = 5'd19;
  localparam pc_t PC_MONTH = 5'd22;
  localparam pc_t PC_WALK  = 5'd25;
  localparam pc_t PC_DONE  = 5'd27;

  // microprogram rom
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      // day number of date a
      5'd0:  w = '{UOP_LOAD_A,    COND_NONE,       PC_START};
      5'd1:  w = '{UOP_Q_Y,       COND_NONE,       PC_START};
      5'd2:  w = '{UOP_LEAP,      COND_NONE,       PC_START};
      5'd3:  w = '{UOP_Q_P,       COND_NONE,       PC_START};
      5'd4:  w = '{UOP_YS,        COND_NONE,       PC_START};
      5'd5:  w = '{UOP_SER,       COND_NONE,       PC_START};
      5'd6:  w = '{UOP_SAVE_A,    COND_OP_SHIFT,   PC_SHIFT};
      // day number of date b, then difference
      5'd7:  w = '{UOP_LOAD_B,    COND_NONE,       PC_START};
      5'd8:  w = '{UOP_Q_Y,       COND_NONE,       PC_START};
      5'd9:  w = '{UOP_LEAP,      COND_NONE,       PC_START};
      5'd10: w = '{UOP_Q_P,       COND_NONE,       PC_START};
      5'd11: w = '{UOP_YS,        COND_NONE,       PC_START};
      5'd12: w = '{UOP_SER,       COND_NONE,       PC_START};
      5'd13: w = '{UOP_FINISH,    COND_NONE,       PC_START};
      // shift: add offset and estimate the year
      5'd14: w = '{UOP_SHIFT_ADD, COND_NONE,       PC_START};
      5'd15: w = '{UOP_EST,       COND_NONE,       PC_START};
      // walk the year up while next year starts at or before s
      5'd16: w = '{UOP_Q_Y,       COND_NONE,       PC_START};
      5'd17: w = '{UOP_YS_NEXT,   COND_UP_DONE,    PC_DOWN};
      5'd18: w = '{UOP_INC,       COND_ALWAYS,     PC_UP};
      // walk the year down while it starts after s
      5'd19: w = '{UOP_Q_P,       COND_NONE,       PC_START};
      5'd20: w = '{UOP_YS,        COND_DOWN_DONE,  PC_MONTH};
      5'd21: w = '{UOP_DEC,       COND_ALWAYS,     PC_DOWN};
      // day of year, then walk the months
      5'd22: w = '{UOP_SUB_YS,    COND_NONE,       PC_START};
      5'd23: w = '{UOP_Q_Y,       COND_NONE,       PC_START};
      5'd24: w = '{UOP_LEAP,      COND_NONE,       PC_START};
      5'd25: w = '{UOP_NOP,       COND_MONTH_DONE, PC_DONE};
      5'd26: w = '{UOP_MSTEP,     COND_ALWAYS,     PC_WALK};
      5'd27: w = '{UOP_FINISH,    COND_NONE,       PC_START};
      default: w = '{UOP_FINISH,  COND_NONE,       PC_START};
    endcase
    return w;
  endfunction

  // days in a month, anything outside 1..12 counts as 31
  function automatic day_t month_len(input month_t m, input logic leap);
    day_t d;
    if (m == MONTH_FEB) begin
      d = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      d = 5'd30;
    end else begin
      d = 5'd31;
    end
    return d;
  endfunction

  // days of the year before the first of month m (m in 1..12)
  function automatic logic [8:0] cum_days(input month_t m, input logic leap);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && (m > MONTH_FEB)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

  // leap rule from the year and its quotient by 100
  function automatic logic leap_of(input year_t y, input q_t q);
    year_t r;
    r = y - (YEAR_W'(q) * YEAR_W'(100));
    return ((y[1:0] == 2'b00) && (r != '0)) || ((r == '0) && (q[1:0] == 2'b00));
  endfunction

  // first day number of year p+1, with q = p / 100
  function automatic serial_t year_start(input year_t p, input q_t q);
    logic [SER_W-1:0] t;
    t = (SER_W'(p) * SER_W'(365)) + SER_W'(p >> 2) - SER_W'(q) + SER_W'(q >> 2);
    return $signed(t);
  endfunction

  // month used for day numbers: 0 reads as 1, above 12 as 12
  function automatic month_t clamp_month(input month_t m);
    month_t c;
    if (m < MONTH_MIN) begin
      c = MONTH_MIN;
    end else if (m > MONTH_MAX) begin
      c = MONTH_MAX;
    end else begin
      c = m;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gregorian_date_arithmetic.sv =====
`default_nettype none

// channel  signals                      payload     accepted when
// req      req_valid / req_ready        gda_req_t   req_valid && req_ready
// rsp      rsp_valid / rsp_ready        gda_rsp_t   rsp_valid && rsp_ready
//
// a difference runs the two day-number passes; a shift's length is set by
// the year correction loop and the month walk, with the steps running one at a time
// on the shared 22x13 multiplier and year-start adder.
// one item is in work at a time; the next is taken while a result waits.
// rst clears the sequencer and the output valid; no clearing pass.
// a full output register holds the sequencer on its finish step.

module gregorian_date_arithmetic (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire gda_pkg::gda_req_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output gda_pkg::gda_rsp_t      rsp
);
  import gda_pkg::*;

  gda_req_t item;
  logic     busy;
  pc_t      pc;
  uword_t   uw;
  logic     jump;
  logic     fin_fire;
  logic     req_fire;

  year_t    yr;
  month_t   mo;
  day_t     dy;
  q_t       q;
  logic     leap;
  serial_t  ys;
  serial_t  acc;
  serial_t  sa;
  logic     invalid;
  logic     oor;

  gda_rsp_t out_r;
  logic     out_valid;
  gda_rsp_t rsp_next;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic [MUL_P_W-RECIP_YEAR_SH-1:0] est;
  year_t    est_year;
  year_t    ys_p;
  serial_t  ys_val;
  serial_t  ser_val;
  serial_t  shift_sum;
  serial_t  dif;
  logic [SER_W-1:0] mag;
  day_t     md_cur;
  logic     invalid_a;
  logic     a_first;
  logic     equal;

  // control word for this step
  assign uw       = ucode(pc);
  assign req_ready = !busy;
  assign req_fire = req_valid && req_ready;
  assign fin_fire = busy && (uw.op == UOP_FINISH) && (!out_valid || rsp_ready);
  assign rsp_valid = out_valid;
  assign rsp       = out_r;

  // shared multiplier: quotient by 100 or year estimate
  always_comb begin
    case (uw.op)
      UOP_Q_P: begin
        mul_a = MUL_A_W'(yr - YEAR_W'(1));
        mul_b = RECIP_100;
      end
      UOP_EST: begin
        mul_a = acc[MUL_A_W-1:0];
        mul_b = RECIP_YEAR;
      end
      default: begin
        mul_a = MUL_A_W'(yr);
        mul_b = RECIP_100;
      end
    endcase
  end

  assign prod = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  assign est  = prod[MUL_P_W-1:RECIP_YEAR_SH] + 1'b1;
  assign est_year = (est > (MUL_P_W-RECIP_YEAR_SH)'(YEAR_MAX)) ? YEAR_MAX : est[YEAR_W-1:0];

  // year start of yr (or yr+1 on the upward walk)
  assign ys_p   = (uw.op == UOP_YS_NEXT) ? yr : (yr - YEAR_W'(1));
  assign ys_val = ((uw.op == UOP_YS) && (yr == '0)) ? YEAR0_START : year_start(ys_p, q);

  // day number, shift and difference arithmetic
  assign md_cur    = month_len(mo, leap);
  assign ser_val   = ys + $signed(SER_W'(cum_days(mo, leap))) + $signed(SER_W'(dy))
                     - $signed(SER_W'(1));
  assign shift_sum = sa + SER_W'($signed(item.offset_days));
  assign dif       = sa - acc;
  assign mag       = dif[SER_W-1] ? SER_W'(-dif) : SER_W'(dif);

  // flags that come straight from the item
  assign invalid_a = !(item.a_month inside {[MONTH_MIN:MONTH_MAX]}) || (item.a_day == '0) ||
                     (item.a_day > month_len(item.a_month, leap));
  assign a_first = (item.a_year < item.b_year) ||
                   ((item.a_year == item.b_year) &&
                    ((item.a_month < item.b_month) ||
                     ((item.a_month == item.b_month) && (item.a_day < item.b_day))));
  assign equal  = (item.a_year == item.b_year) && (item.a_month == item.b_month) &&
                  (item.a_day == item.b_day);

  // jump condition
  always_comb begin
    case (uw.cond)
      COND_NONE:       jump = 1'b0;
      COND_ALWAYS:     jump = 1'b1;
      COND_OP_SHIFT:   jump = (item.opcode == OPC_SHIFT);
      COND_UP_DONE:    jump = (yr >= YEAR_MAX) || (ys_val > acc);
      COND_DOWN_DONE:  jump = (yr <= YEAR_MIN) || (ys_val <= acc);
      COND_MONTH_DONE: jump = (mo >= MONTH_MAX) || (acc < $signed(SER_W'(md_cur)));
      default:         jump = 1'b0;
    endcase
  end

  // result assembly
  always_comb begin
    rsp_next            = '0;
    rsp_next.a_before_b = a_first;
    rsp_next.a_equals_b = equal;
    rsp_next.a_invalid  = invalid;
    if (item.opcode == OPC_SHIFT) begin
      rsp_next.out_year     = yr;
      rsp_next.out_month    = mo;
      rsp_next.out_day      = acc[DAY_W-1:0] + 1'b1;
      rsp_next.out_of_range = oor;
    end else if (mag > SER_W'(COUNT_MAX)) begin
      rsp_next.day_count    = COUNT_MAX;
      rsp_next.out_of_range = 1'b1;
    end else begin
      rsp_next.day_count    = mag[COUNT_W-1:0];
    end
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= PC_START;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces a leaving one in the same cycle
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        out_valid <= 1'b0;
      end
      if (req_fire) begin
        busy <= 1'b1;
        pc   <= PC_START;
      end else if (busy) begin
        if (uw.op == UOP_FINISH) begin
          if (fin_fire) begin
            busy <= 1'b0;
          end
        end else if (jump) begin
          pc <= uw.target;
        end else begin
          pc <= pc + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req_fire) begin
      item <= req;
    end
    if (fin_fire) begin
      out_r <= rsp_next;
    end
    if (busy) begin
      case (uw.op)
        UOP_LOAD_A: begin
          yr <= item.a_year;
          mo <= clamp_month(item.a_month);
          dy <= item.a_day;
        end
        UOP_LOAD_B: begin
          yr <= item.b_year;
          mo <= clamp_month(item.b_month);
          dy <= item.b_day;
        end
        UOP_Q_Y, UOP_Q_P: begin
          q <= prod[RECIP_100_SH +: Q_W];
        end
        UOP_LEAP: begin
          leap <= leap_of(yr, q);
        end
        UOP_YS, UOP_YS_NEXT: begin
          ys <= ys_val;
        end
        UOP_SER: begin
          acc <= ser_val;
        end
        UOP_SAVE_A: begin
          sa      <= acc;
          invalid <= invalid_a;
        end
        UOP_SHIFT_ADD: begin
          if (shift_sum[SER_W-1]) begin
            acc <= '0;
            oor <= 1'b1;
          end else if (shift_sum > SERIAL_LAST) begin
            acc <= SERIAL_LAST;
            oor <= 1'b1;
          end else begin
            acc <= shift_sum;
            oor <= 1'b0;
          end
        end
        UOP_EST: begin
          yr <= est_year;
        end
        UOP_INC: begin
          yr <= yr + 1'b1;
        end
        UOP_DEC: begin
          yr <= yr - 1'b1;
        end
        UOP_SUB_YS: begin
          acc <= acc - ys;
          mo  <= MONTH_MIN;
        end
        UOP_MSTEP: begin
          acc <= acc - $signed(SER_W'(md_cur));
          mo  <= mo + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // a finished item leaves the sequencer and shows at the output
  a_finish_hands_off: assert property (@(posedge clk) disable iff (rst)
    fin_fire |=> !busy && rsp_valid)
    else $error("finish step did not hand the item to the output");

  // a shifted date always has its year and month in range and a nonzero day
  a_shift_date_legal: assert property (@(posedge clk) disable iff (rst)
    fin_fire && (item.opcode == OPC_SHIFT) |=>
      (rsp.out_year >= YEAR_MIN) && (rsp.out_year <= YEAR_MAX) &&
      (rsp.out_month >= MONTH_MIN) && (rsp.out_month <= MONTH_MAX) && (rsp.out_day != '0))
    else $error("shift produced an illegal date");

  // the year search never leaves 1..9999
  a_year_bounds: assert property (@(posedge clk) disable iff (rst)
    busy && (pc >= PC_UP) |-> (yr >= YEAR_MIN) && (yr <= YEAR_MAX))
    else $error("year search left the calendar range");

  // the remaining day count on the shift path never goes negative
  a_walk_nonneg: assert property (@(posedge clk) disable iff (rst)
    busy && (pc >= PC_UP) |-> !acc[SER_W-1])
    else $error("day remainder went negative");

endmodule

`default_nettype wire

// ===== tb/sv/gregorian_date_arithmetic_tb.sv =====
`default_nettype none

module gregorian_date_arithmetic_tb;
  import gda_pkg::*;

  localparam int unsigned RANDOM_ITEMS     = 900;
  localparam int unsigned DRAIN_AT         = 600;
  localparam int unsigned LONG_HOLD_AT     = 300;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned IDLE_LIMIT       = 3000;
  localparam int unsigned TAIL_CYCLES      = 80;
  localparam int unsigned PRINT_CAP        = 50;

  typedef enum int unsigned {
    RDY_ALWAYS,
    RDY_THREE_OF_FOUR,
    RDY_COIN,
    RDY_SPARSE
  } ready_mode_t;

  // days and dates on the proleptic calendar, with expected results per item
  class date_scoreboard;
    gda_rsp_t    pending_results[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function bit is_leap_year(longint y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function longint days_in_month(longint y, longint m);
      if (m < 1 || m > 12) return 31;
      if (m == 2) return is_leap_year(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    // day number of january 1 of year y, where 0001-01-01 is day 0
    function longint first_day_of_year(longint y);
      longint p;
      if (y <= 0) return -366;
      p = y - 1;
      return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    // illegal months clamp to 1..12, the day carries linearly
    function longint day_number(longint y, longint m, longint d);
      longint dn;
      longint mc;
      mc = (m < 1) ? 1 : ((m > 12) ? 12 : m);
      dn = first_day_of_year(y);
      for (longint k = 1; k < mc; k++) dn += days_in_month(y, k);
      return dn + d - 1;
    endfunction

    function void date_of_day(input longint dn, output longint y, output longint m,
                              output longint d);
      longint rest;
      y = dn * 400 / 146097 + 1;
      if (y < 1) y = 1;
      while (y < 9999 && first_day_of_year(y + 1) <= dn) y++;
      while (y > 1 && first_day_of_year(y) > dn) y--;
      rest = dn - first_day_of_year(y);
      m = 1;
      while (m < 12 && rest >= days_in_month(y, m)) begin
        rest -= days_in_month(y, m);
        m++;
      end
      d = rest + 1;
    endfunction

    function gda_rsp_t compute_date_result(gda_req_t q);
      gda_rsp_t r;
      longint ay, am, ad, by, bm, bd, off, sa, dn, y, m, d;
      r = '0;
      ay = q.a_year;
      am = q.a_month;
      ad = q.a_day;
      by = q.b_year;
      bm = q.b_month;
      bd = q.b_day;
      off = longint'($signed(q.offset_days));
      sa = day_number(ay, am, ad);
      r.a_before_b = (ay < by) || (ay == by && (am < bm || (am == bm && ad < bd)));
      r.a_equals_b = (ay == by) && (am == bm) && (ad == bd);
      r.a_invalid = (am < 1) || (am > 12) || (ad < 1) || (ad > days_in_month(ay, am));
      if (q.opcode == OPC_SHIFT) begin
        // shift with saturation to the first and last supported day
        dn = sa + off;
        if (dn < 0) begin
          dn = 0;
          r.out_of_range = 1'b1;
        end
        if (dn > longint'(SERIAL_LAST)) begin
          dn = longint'(SERIAL_LAST);
          r.out_of_range = 1'b1;
        end
        date_of_day(dn, y, m, d);
        r.out_year = y[YEAR_W-1:0];
        r.out_month = m[MONTH_W-1:0];
        r.out_day = d[DAY_W-1:0];
      end else begin
        // absolute distance, saturating at the count width
        dn = sa - day_number(by, bm, bd);
        if (dn < 0) dn = -dn;
        if (dn > longint'(COUNT_MAX)) begin
          dn = longint'(COUNT_MAX);
          r.out_of_range = 1'b1;
        end
        r.day_count = dn[COUNT_W-1:0];
      end
      return r;
    endfunction

    task report_mismatch(input string what);
      if (mismatches < PRINT_CAP) $display("mismatch: %s", what);
      mismatches++;
    endtask

    function void note_request(gda_req_t item);
      pending_results.push_back(compute_date_result(item));
    endfunction

    task compare_field(input string name, input longint got, input longint want);
      if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(input gda_rsp_t got);
      gda_rsp_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
        return;
      end
      want = pending_results.pop_front();
      compare_field("out_year", got.out_year, want.out_year);
      compare_field("out_month", got.out_month, want.out_month);
      compare_field("out_day", got.out_day, want.out_day);
      compare_field("day_count", got.day_count, want.day_count);
      compare_field("a_before_b", got.a_before_b, want.a_before_b);
      compare_field("a_equals_b", got.a_equals_b, want.a_equals_b);
      compare_field("a_invalid", got.a_invalid, want.a_invalid);
      compare_field("out_of_range", got.out_of_range, want.out_of_range);
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  gda_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  gda_rsp_t rsp;

  date_scoreboard sb;

  int unsigned burst_left = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  int unsigned pattern_cycle = 0;
  int unsigned idle_cycles = 0;
  ready_mode_t stall_mode = RDY_ALWAYS;

  gregorian_date_arithmetic dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic gda_req_t make_request(logic op, longint ay, longint am, longint ad,
                                            longint by, longint bm, longint bd,
                                            longint off);
    gda_req_t r;
    r.opcode = op;
    r.a_year = ay[YEAR_W-1:0];
    r.a_month = am[MONTH_W-1:0];
    r.a_day = ad[DAY_W-1:0];
    r.b_year = by[YEAR_W-1:0];
    r.b_month = bm[MONTH_W-1:0];
    r.b_day = bd[DAY_W-1:0];
    r.offset_days = off[OFF_W-1:0];
    return r;
  endfunction

  // years weighted toward the range ends and century years
  function automatic longint pick_year();
    case ($urandom_range(0, 9))
      0: return longint'($urandom_range(1, 5));
      1: return longint'($urandom_range(9995, 9999));
      2: return 100 * longint'($urandom_range(15, 24));
      default: return longint'($urandom_range(1, 9999));
    endcase
  endfunction

  function automatic gda_req_t random_request();
    int unsigned kind;
    longint      ay, am, ad, by, bm, bd, off;
    logic [95:0] bits;
    kind = $urandom_range(0, 99);
    ay = pick_year();
    am = $urandom_range(1, 12);
    ad = $urandom_range(1, sb.days_in_month(ay, am));
    by = pick_year();
    bm = $urandom_range(1, 12);
    bd = $urandom_range(1, sb.days_in_month(by, bm));
    if (kind < 45) begin
      // legal date, half of them short shifts
      case ($urandom_range(0, 3))
        0, 1: off = longint'($urandom_range(0, 800)) - 400;
        2: off = longint'($urandom_range(0, 80000)) - 40000;
        default: off = longint'($urandom_range(0, 1048575)) - 524288;
      endcase
      return make_request(OPC_SHIFT, ay, am, ad, by, bm, bd, off);
    end else if (kind < 80) begin
      // legal dates, some equal or in the same month
      off = longint'($urandom_range(0, 1048575)) - 524288;
      case ($urandom_range(0, 3))
        0: return make_request(OPC_DIFF, ay, am, ad, ay, am, ad, off);
        1: return make_request(OPC_DIFF, ay, am, ad, ay, am,
                               $urandom_range(1, sb.days_in_month(ay, am)), off);
        default: return make_request(OPC_DIFF, ay, am, ad, by, bm, bd, off);
      endcase
    end
    // raw bits: any year, month and day the fields can hold
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(gda_req_t)-1:0];
  endfunction

  // offer one item after a burst gap and wait for it to be taken
  task automatic send_item(input gda_req_t item);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(item);
  endtask

  task automatic send_directed();
    // leap day carries forward
    send_item(make_request(OPC_SHIFT, 2024, 2, 28, 2024, 3, 1, 1));
    send_item(make_request(OPC_SHIFT, 2023, 2, 28, 2023, 2, 28, 1));
    send_item(make_request(OPC_SHIFT, 1900, 2, 28, 1901, 1, 1, 1));
    send_item(make_request(OPC_SHIFT, 2000, 2, 28, 1999, 12, 31, 1));
    // backward carry through month and year ends
    send_item(make_request(OPC_SHIFT, 2024, 3, 1, 2024, 3, 1, -1));
    send_item(make_request(OPC_SHIFT, 2021, 1, 1, 2020, 12, 31, -1));
    // saturation at both ends of the calendar
    send_item(make_request(OPC_SHIFT, 1, 1, 1, 1, 1, 1, -1));
    send_item(make_request(OPC_SHIFT, 9999, 12, 31, 1, 1, 1, 1));
    send_item(make_request(OPC_SHIFT, 1, 1, 1, 9999, 12, 31, 524287));
    send_item(make_request(OPC_SHIFT, 9999, 12, 31, 9999, 12, 31, -524288));
    send_item(make_request(OPC_SHIFT, 16383, 12, 31, 1, 1, 1, 0));
    // illegal month, day zero and day past the month end
    send_item(make_request(OPC_SHIFT, 2020, 0, 15, 2020, 1, 15, 0));
    send_item(make_request(OPC_SHIFT, 2020, 15, 31, 2020, 12, 31, 0));
    send_item(make_request(OPC_SHIFT, 2020, 3, 0, 2020, 2, 29, 0));
    send_item(make_request(OPC_SHIFT, 2021, 4, 31, 2021, 5, 1, 0));
    // year zero counts as leap
    send_item(make_request(OPC_SHIFT, 0, 6, 15, 0, 6, 15, 400));
    send_item(make_request(OPC_SHIFT, 1999, 12, 31, 1999, 12, 31, 0));
    // differences: equal, full span, saturated, ordering by each field
    send_item(make_request(OPC_DIFF, 2000, 1, 1, 2000, 1, 1, 0));
    send_item(make_request(OPC_DIFF, 1, 1, 1, 9999, 12, 31, 0));
    send_item(make_request(OPC_DIFF, 16383, 15, 31, 0, 0, 0, -1));
    send_item(make_request(OPC_DIFF, 2020, 5, 10, 2020, 5, 9, 0));
    send_item(make_request(OPC_DIFF, 2020, 4, 30, 2020, 5, 1, 0));
    send_item(make_request(OPC_DIFF, 2020, 1, 1, 2020, 0, 0, 0));
    send_item(make_request(OPC_DIFF, 2000, 2, 28, 2000, 3, 1, 0));
  endtask

  // result side: stall pattern, one long hold, and checking
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        sb.check_result(rsp);
        results_seen++;
        if (results_seen == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
      end
      pattern_cycle++;
      if (pattern_cycle % 64 == 0) stall_mode = ready_mode_t'($urandom_range(0, 3));
      if (hold_left != 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        case (stall_mode)
          RDY_ALWAYS:        rsp_ready <= 1'b1;
          RDY_THREE_OF_FOUR: rsp_ready <= (pattern_cycle % 4) != 0;
          RDY_COIN:          rsp_ready <= 1'($urandom_range(0, 1));
          default:           rsp_ready <= (pattern_cycle % 5) == 0;
        endcase
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_directed();
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == DRAIN_AT) begin
        // pause until every result is back
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
      end
      send_item(random_request());
    end
    req_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
